[rtl/core/frm_pkg.sv]
`default_nettype none
package frm_pkg;

   localparam int RATE_W = 32;
   localparam int TS_W = 32;
   localparam int WIN_MS_W = 16;
   localparam int WIN_CNT_W = 24;
   localparam int SES_CNT_W = 32;
   localparam int MS_W = 10;
   localparam int CSR_DATA_W = 16;

   localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
   localparam logic [WIN_MS_W-1:0] WIN_MS_RESET = WIN_MS_W'(1000);
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FRAME = 2'd0;
   localparam kind_type KIND_WINDOW = 2'd1;
   localparam kind_type KIND_REPORT = 2'd2;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_MEASURE_ENABLE = 1'd0;
   localparam csr_index_type CSR_WINDOW_MS = 1'd1;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } stat_type;

   typedef struct packed {
      kind_type kind;
      logic [RATE_W-1:0] rate_q8;
      logic [RATE_W-1:0] best_q8;
      logic [RATE_W-1:0] worst_q8;
      logic zero_elapsed;
   } rsp_payload_type;

endpackage
`default_nettype wire

[rtl/core/frm_req_if.sv]
`default_nettype none
interface frm_req_if;
   import frm_pkg::*;

   logic valid;
   logic ready;
   logic operation;
   logic [TS_W-1:0] timestamp_ms;

   modport source (output valid, output operation, output timestamp_ms, input ready);
   modport sink (input valid, input operation, input timestamp_ms, output ready);
endinterface
`default_nettype wire

[rtl/core/frm_rsp_if.sv]
`default_nettype none
interface frm_rsp_if;
   import frm_pkg::*;

   logic valid;
   logic ready;
   kind_type kind;
   logic [RATE_W-1:0] rate_q8;
   logic [RATE_W-1:0] best_q8;
   logic [RATE_W-1:0] worst_q8;
   logic zero_elapsed;

   modport source (output valid, output kind, output rate_q8, output best_q8,
                   output worst_q8, output zero_elapsed, input ready);
   modport sink (input valid, input kind, input rate_q8, input best_q8,
                 input worst_q8, input zero_elapsed, output ready);
endinterface
`default_nettype wire

[rtl/core/frame_rate_meter_top.sv]
`default_nettype none
// Frame rate meter. Each request is a frame event or a report, stamped in
// milliseconds, and yields exactly one response. A request that needs no
// division goes through load, preparation, multiply and finish to the
// response register; one that produces a window rate or a report over a
// nonzero elapsed time also passes through the restoring divider, which
// retires one quotient bit per cycle. One request is processed at a time;
// the next request is accepted as soon as the previous one has reached the
// response register, even while that response waits to be taken.
// Configuration writes must only be made while the block is idle.
module frame_rate_meter_top #(
   parameter int FRAC_BITS = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   frm_req_if.sink                             req_ch,
   frm_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire frm_pkg::csr_index_type         csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import frm_pkg::*;

   cmd_type         cmd;
   stat_type        stat;
   rsp_payload_type rsp_payload;

   frm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   frm_dp #(
      .FRAC_BITS (FRAC_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_ch.operation),
      .req_timestamp_ms (req_ch.timestamp_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_payload      (rsp_payload)
   );

   assign rsp_ch.kind = rsp_payload.kind;
   assign rsp_ch.rate_q8 = rsp_payload.rate_q8;
   assign rsp_ch.best_q8 = rsp_payload.best_q8;
   assign rsp_ch.worst_q8 = rsp_payload.worst_q8;
   assign rsp_ch.zero_elapsed = rsp_payload.zero_elapsed;
endmodule
`default_nettype wire

[rtl/core/frm_dp.sv]
`default_nettype none
module frm_dp #(
   parameter int FRAC_BITS = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire frm_pkg::cmd_type              cmd,
   output frm_pkg::stat_type                  stat,
   input  wire logic                          req_operation,
   input  wire logic [frm_pkg::TS_W-1:0]      req_timestamp_ms,
   input  wire logic                          csr_we,
   input  wire frm_pkg::csr_index_type        csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output frm_pkg::rsp_payload_type           rsp_payload
);
   import frm_pkg::*;

   localparam int NUM_W = SES_CNT_W + MS_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                  meas_en_ff, meas_en_in;
   logic [WIN_MS_W-1:0]   win_ms_ff, win_ms_in;
   logic                  ses_started_ff, ses_started_in;
   logic [TIME_BITS-1:0]  ses_start_ff, ses_start_in;
   logic                  win_started_ff, win_started_in;
   logic [TIME_BITS-1:0]  win_start_ff, win_start_in;
   logic [WIN_CNT_W-1:0]  win_frames_ff, win_frames_in;
   logic [SES_CNT_W-1:0]  ses_frames_ff, ses_frames_in;
   logic [RATE_W-1:0]     best_ff, best_in;
   logic [RATE_W-1:0]     worst_ff, worst_in;

   logic                  op_ff, op_in;
   logic [TIME_BITS-1:0]  t_ff, t_in;
   kind_type              kind_ff, kind_in;
   logic                  zero_ff, zero_in;
   logic                  need_div_ff, need_div_in;
   logic [SES_CNT_W-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0]  divisor_ff, divisor_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [WIN_CNT_W-1:0]  wf_inc;
   logic [TIME_BITS-1:0]  win_el;
   logic [TIME_BITS-1:0]  ses_el;
   logic [TIME_BITS:0]    trial;
   logic [TIME_BITS:0]    trial_diff;
   logic                  trial_ge;
   logic [RATE_W-1:0]     quot_sat;
   logic [RATE_W-1:0]     rate_val;
   logic [RATE_W-1:0]     best_new;
   logic [RATE_W-1:0]     worst_new;

   assign wf_inc = (&win_frames_ff) ? win_frames_ff : win_frames_ff + WIN_CNT_W'(1);
   assign win_el = t_ff - win_start_ff;
   assign ses_el = t_ff - ses_start_ff;
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge = trial >= {1'b0, divisor_ff};
   assign quot_sat = (|num_ff[NUM_W-1:RATE_W]) ? RATE_MAX : num_ff[RATE_W-1:0];

   always_comb begin
      if (kind_ff == KIND_FRAME) begin
         rate_val = '0;
      end else if (zero_ff) begin
         rate_val = RATE_MAX;
      end else begin
         rate_val = quot_sat;
      end
   end

   assign best_new = (rate_val > best_ff) ? rate_val : best_ff;
   assign worst_new = (worst_ff == '0 || rate_val < worst_ff) ? rate_val : worst_ff;

   always_comb begin
      meas_en_in = meas_en_ff;
      win_ms_in = win_ms_ff;
      ses_started_in = ses_started_ff;
      ses_start_in = ses_start_ff;
      win_started_in = win_started_ff;
      win_start_in = win_start_ff;
      win_frames_in = win_frames_ff;
      ses_frames_in = ses_frames_ff;
      best_in = best_ff;
      worst_in = worst_ff;
      op_in = op_ff;
      t_in = t_ff;
      kind_in = kind_ff;
      zero_in = zero_ff;
      need_div_in = need_div_ff;
      count_in = count_ff;
      divisor_in = divisor_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MEASURE_ENABLE: meas_en_in = csr_wdata[0];
            CSR_WINDOW_MS: win_ms_in = csr_wdata[WIN_MS_W-1:0];
            default: meas_en_in = meas_en_ff;
         endcase
      end

      if (cmd.load) begin
         op_in = req_operation;
         t_in = TIME_BITS'(req_timestamp_ms);
      end

      if (cmd.prep) begin
         kind_in = KIND_FRAME;
         zero_in = 1'b0;
         need_div_in = 1'b0;
         count_in = '0;
         divisor_in = '0;
         if (op_ff == OP_FRAME) begin
            if (!(&ses_frames_ff)) begin
               ses_frames_in = ses_frames_ff + SES_CNT_W'(1);
            end
            if (!ses_started_ff) begin
               ses_started_in = 1'b1;
               ses_start_in = t_ff;
            end
            if (meas_en_ff) begin
               win_frames_in = wf_inc;
               if (win_started_ff) begin
                  if (win_el >= TIME_BITS'(win_ms_ff)) begin
                     kind_in = KIND_WINDOW;
                     count_in = SES_CNT_W'(wf_inc);
                     divisor_in = win_el;
                     zero_in = (win_el == '0);
                     need_div_in = (win_el != '0);
                  end
               end else begin
                  win_started_in = 1'b1;
                  win_start_in = t_ff;
               end
            end
         end else begin
            kind_in = KIND_REPORT;
            count_in = ses_frames_ff;
            divisor_in = ses_el;
            zero_in = (ses_el == '0);
            need_div_in = (ses_el != '0);
         end
      end

      if (cmd.mul) begin
         num_in = (NUM_W'(count_ff) * NUM_W'(MS_PER_S)) << FRAC_BITS;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end

      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
         num_in = {num_ff[NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (cmd.finish) begin
         rsp_in.kind = kind_ff;
         rsp_in.rate_q8 = rate_val;
         rsp_in.zero_elapsed = zero_ff;
         rsp_in.best_q8 = best_ff;
         rsp_in.worst_q8 = worst_ff;
         unique case (kind_ff)
            KIND_WINDOW: begin
               win_start_in = t_ff;
               win_frames_in = '0;
               best_in = best_new;
               worst_in = worst_new;
               rsp_in.best_q8 = best_new;
               rsp_in.worst_q8 = worst_new;
            end
            KIND_REPORT: begin
               ses_started_in = 1'b0;
               ses_start_in = '0;
               win_started_in = 1'b0;
               win_start_in = '0;
               win_frames_in = '0;
               ses_frames_in = '0;
               best_in = '0;
               worst_in = '0;
            end
            default: begin
               best_in = best_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_en_ff <= 1'b0;
         win_ms_ff <= WIN_MS_RESET;
         ses_started_ff <= 1'b0;
         ses_start_ff <= '0;
         win_started_ff <= 1'b0;
         win_start_ff <= '0;
         win_frames_ff <= '0;
         ses_frames_ff <= '0;
         best_ff <= '0;
         worst_ff <= '0;
         cnt_ff <= '0;
      end else begin
         meas_en_ff <= meas_en_in;
         win_ms_ff <= win_ms_in;
         ses_started_ff <= ses_started_in;
         ses_start_ff <= ses_start_in;
         win_started_ff <= win_started_in;
         win_start_ff <= win_start_in;
         win_frames_ff <= win_frames_in;
         ses_frames_ff <= ses_frames_in;
         best_ff <= best_in;
         worst_ff <= worst_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      t_ff <= t_in;
      kind_ff <= kind_in;
      zero_ff <= zero_in;
      need_div_ff <= need_div_in;
      count_ff <= count_in;
      divisor_ff <= divisor_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign stat.need_div = need_div_ff;
   assign stat.div_last = (cnt_ff == CNT_W'(1));
   assign rsp_payload = rsp_ff;

   // The divider remainder must always stay below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < divisor_ff))
      else $error("divider remainder reached the divisor");

   // A window rate never clears the worst rate unless the rate itself is zero.
   a_worst_tracks: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == KIND_WINDOW && rate_val != '0) |=> (worst_ff != '0))
      else $error("worst rate lost after a nonzero window rate");

   // A report leaves the session empty.
   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == KIND_REPORT) |=>
         (!ses_started_ff && ses_frames_ff == '0 && best_ff == '0))
      else $error("session state survived a report");
endmodule
`default_nettype wire

[rtl/core/frm_ctrl.sv]
`default_nettype none
module frm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output frm_pkg::cmd_type       cmd,
   input  wire frm_pkg::stat_type stat
);
   import frm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = stat.need_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted request always moves on to preparation.
   a_load_to_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_PREP))
      else $error("accepted request did not enter preparation");

   // A result is only loaded when the output register is free.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending response");

   // The last divide step hands over to the finish state.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && stat.div_last) |=> (state_ff == S_FIN))
      else $error("divider did not stop after its last step");

   // Finishing shows the response and frees the input side.
   a_finish_show: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result not presented");
endmodule
`default_nettype wire

[tb/frm_checker.sv]
`default_nettype none
module frm_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   frm_req_if                                  req_ch,
   frm_rsp_if                                  rsp_ch,
   input  wire logic                           csr_we,
   input  wire frm_pkg::csr_index_type         csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  error_count,
   output int                                  awaiting,
   output int                                  checked_count,
   output int                                  window_count,
   output int                                  report_count,
   output int                                  zero_count
);
   import frm_pkg::*;

   localparam int FRAC_BITS = 8;

   logic                 meas_en;
   logic [WIN_MS_W-1:0]  win_len;
   logic                 sess_open;
   logic [TS_W-1:0]      sess_t0;
   logic                 win_open;
   logic [TS_W-1:0]      win_t0;
   logic [WIN_CNT_W-1:0] win_frames;
   logic [SES_CNT_W-1:0] sess_frames;
   logic [RATE_W-1:0]    best_q;
   logic [RATE_W-1:0]    worst_q;

   rsp_payload_type predicted_readings[$];
   int mismatches;
   int n_checked;
   int n_window;
   int n_report;
   int n_zero;

   function automatic logic [RATE_W-1:0] rate_over(input logic [63:0] count,
                                                    input logic [TS_W-1:0] span,
                                                    output logic zero);
      logic [63:0] quotient;
      zero = (span == '0);
      if (zero) return RATE_MAX;
      quotient = ((count * 64'(MS_PER_S)) << FRAC_BITS) / 64'(span);
      return (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
   endfunction

   function automatic void clear_session();
      sess_open = 1'b0;
      sess_t0 = '0;
      win_open = 1'b0;
      win_t0 = '0;
      win_frames = '0;
      sess_frames = '0;
      best_q = '0;
      worst_q = '0;
   endfunction

   function automatic rsp_payload_type meter_step(input logic op, input logic [TS_W-1:0] ts);
      rsp_payload_type r;
      logic [TS_W-1:0] span;
      logic zero;
      r.kind = KIND_FRAME;
      r.rate_q8 = '0;
      r.zero_elapsed = 1'b0;
      if (op == OP_FRAME) begin
         if (sess_frames != '1) sess_frames++;
         if (!sess_open) begin
            sess_open = 1'b1;
            sess_t0 = ts;
         end
         if (meas_en) begin
            if (win_frames != '1) win_frames++;
            if (win_open) begin
               span = ts - win_t0;
               if (span >= TS_W'(win_len)) begin
                  r.rate_q8 = rate_over(64'(win_frames), span, zero);
                  r.zero_elapsed = zero;
                  r.kind = KIND_WINDOW;
                  win_t0 = ts;
                  win_frames = '0;
                  if (worst_q == '0 || r.rate_q8 < worst_q) worst_q = r.rate_q8;
                  if (r.rate_q8 > best_q) best_q = r.rate_q8;
               end
            end else begin
               win_open = 1'b1;
               win_t0 = ts;
            end
         end
         r.best_q8 = best_q;
         r.worst_q8 = worst_q;
      end else begin
         span = ts - sess_t0;
         r.rate_q8 = rate_over(64'(sess_frames), span, zero);
         r.zero_elapsed = zero;
         r.kind = KIND_REPORT;
         r.best_q8 = best_q;
         r.worst_q8 = worst_q;
         clear_session();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      logic bad;
      if (reset) begin
         meas_en = 1'b0;
         win_len = WIN_MS_RESET;
         clear_session();
         predicted_readings.delete();
         mismatches = 0;
         n_checked = 0;
         n_window = 0;
         n_report = 0;
         n_zero = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MEASURE_ENABLE: meas_en = csr_wdata[0];
               CSR_WINDOW_MS: win_len = csr_wdata[WIN_MS_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted_readings.push_back(meter_step(req_ch.operation, req_ch.timestamp_ms));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.kind;
            got.rate_q8 = rsp_ch.rate_q8;
            got.best_q8 = rsp_ch.best_q8;
            got.worst_q8 = rsp_ch.worst_q8;
            got.zero_elapsed = rsp_ch.zero_elapsed;
            n_checked++;
            if (got.kind == KIND_WINDOW) n_window++;
            if (got.kind == KIND_REPORT) n_report++;
            if (got.zero_elapsed === 1'b1) n_zero++;
            if (predicted_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected response with no request outstanding: kind %0d rate %h",
                           got.kind, got.rate_q8);
               end
            end else begin
               want = predicted_readings.pop_front();
               bad = (got.kind !== want.kind) || (got.rate_q8 !== want.rate_q8) ||
                     (got.best_q8 !== want.best_q8) || (got.worst_q8 !== want.worst_q8) ||
                     (got.zero_elapsed !== want.zero_elapsed);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch: expected kind %0d rate %h best %h worst %h zero %0d",
                              want.kind, want.rate_q8, want.best_q8, want.worst_q8,
                              want.zero_elapsed);
                     $display("          actual   kind %0d rate %h best %h worst %h zero %0d",
                              got.kind, got.rate_q8, got.best_q8, got.worst_q8,
                              got.zero_elapsed);
                  end
               end
            end
         end
      end
      error_count <= mismatches;
      awaiting <= predicted_readings.size();
      checked_count <= n_checked;
      window_count <= n_window;
      report_count <= n_report;
      zero_count <= n_zero;
   end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
   import frm_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int BURST_FRAMES = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS = 128;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_MEASURE_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   logic [WIN_MS_W-1:0] cur_window = WIN_MS_RESET;

   int error_count;
   int awaiting;
   int checked_count;
   int window_count;
   int report_count;
   int zero_count;

   frm_req_if req_ch ();
   frm_rsp_if rsp_ch ();

   frame_rate_meter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frm_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .awaiting      (awaiting),
      .checked_count (checked_count),
      .window_count  (window_count),
      .report_count  (report_count),
      .zero_count    (zero_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The response side either follows the stall rate or, when asked, holds off
   // for a long stretch so that the meter backs up into its request channel.
   always @(posedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_req(input logic op, input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.timestamp_ms <= ts;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic reconfigure(input logic en, input logic [WIN_MS_W-1:0] win);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_MEASURE_ENABLE;
      csr_wdata <= CSR_DATA_W'(en);
      @(posedge clock);
      csr_index <= CSR_WINDOW_MS;
      csr_wdata <= CSR_DATA_W'(win);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_window = win;
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct,
                               input bit with_hold, input bit with_pause);
      logic [TS_W-1:0] now;
      logic [WIN_MS_W-1:0] win;
      logic en;
      int pick;
      int step_pick;
      wait_idle();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      pick = $urandom_range(99);
      if (pick < 25) win = WIN_MS_W'($urandom_range(1, 20));
      else if (pick < 75) win = WIN_MS_W'($urandom_range(20, 2000));
      else win = WIN_MS_W'($urandom_range(1, 65535));
      en = ($urandom_range(99) < 85);
      reconfigure(en, win);
      now = $urandom();
      if (with_hold) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ((with_pause && i == PHASE_ITEMS / 2) || $urandom_range(199) == 0) wait_idle();
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_req(OP_REPORT, now + TS_W'($urandom_range(0, 3)));
         end else if (pick < 9) begin
            send_req(OP_FRAME, $urandom());
         end else begin
            step_pick = $urandom_range(99);
            if (step_pick < 15) now = now;
            else if (step_pick < 20) now = now + $urandom();
            else now = now + TS_W'($urandom_range(0, 2 * int'(cur_window) / 3 + 1));
            send_req(OP_FRAME, now);
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_FRAME;
      req_ch.timestamp_ms = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reports before any frame, window rates, wrapping time and a report
      // at the session start.
      reconfigure(1'b1, 16'd1000);
      send_req(OP_REPORT, 32'd0);
      send_req(OP_REPORT, 32'd12345);
      send_req(OP_FRAME, 32'd100);
      send_req(OP_FRAME, 32'd600);
      send_req(OP_FRAME, 32'd1100);
      send_req(OP_FRAME, 32'd1700);
      send_req(OP_FRAME, 32'd3100);
      send_req(OP_FRAME, 32'd3600);
      send_req(OP_FRAME, 32'd4100);
      send_req(OP_REPORT, 32'd4100);
      send_req(OP_FRAME, 32'hFFFF_FF00);
      send_req(OP_FRAME, 32'h0000_02E8);
      send_req(OP_REPORT, 32'h0000_02E8);
      send_req(OP_FRAME, 32'hFFFF_FFFF);
      send_req(OP_REPORT, 32'hFFFF_FFFF);

      // Measurement off, then on again with the shortest window; the old
      // window must carry on after a second pause.
      reconfigure(1'b0, 16'd1000);
      send_req(OP_FRAME, 32'd5000);
      send_req(OP_FRAME, 32'd7000);
      reconfigure(1'b1, 16'd1);
      send_req(OP_FRAME, 32'd7000);
      send_req(OP_FRAME, 32'd7000);
      send_req(OP_FRAME, 32'd7001);
      reconfigure(1'b0, 16'd1);
      send_req(OP_FRAME, 32'd7005);
      reconfigure(1'b1, 16'd1);
      send_req(OP_FRAME, 32'd7010);

      // A zero window gives a zero divisor; then the longest window.
      reconfigure(1'b1, 16'd0);
      send_req(OP_FRAME, 32'd9000);
      send_req(OP_FRAME, 32'd9000);
      reconfigure(1'b1, 16'd65535);
      send_req(OP_FRAME, 32'd9000 + 32'd65534);
      send_req(OP_FRAME, 32'd9000 + 32'd65535);
      send_req(OP_REPORT, 32'd9000 + 32'd65535);

      // A burst of frames within one millisecond gives a high window rate
      // and a high session average.
      reconfigure(1'b1, 16'd1);
      for (int i = 0; i < BURST_FRAMES; i++) send_req(OP_FRAME, 32'h8000_0000);
      send_req(OP_FRAME, 32'h8000_0001);
      send_req(OP_REPORT, 32'h8000_0001);

      random_phase(0, 0, 1'b0, 1'b0);
      random_phase(54, 0, 1'b0, 1'b1);
      random_phase(0, 54, 1'b0, 1'b0);
      random_phase(30, 30, 1'b0, 1'b0);
      random_phase(0, 0, 1'b1, 1'b1);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses: %0d window rates, %0d reports, %0d zero-divisor results.",
               checked_count, window_count, report_count, zero_count);
      $display("Covered directed corners, a %0d-frame burst and five random phases.",
               BURST_FRAMES);
      if (error_count == 0 && awaiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
